// File: hdl/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types and constants for the priority scheduler.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int NUM_W   = 5;
  localparam int TIME_W  = 20;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One classified job as it travels from the front end to the back end.
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [NUM_W-1:0]   num;
    logic               keep;   // stored (0: dropped for lack of room)
    logic               last;   // closes the set
  } job_item_t;

  // One job store entry.
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [NUM_W-1:0]   num;
  } entry_t;

  // One scheduled result.
  typedef struct packed {
    logic [NUM_W-1:0]   job_number;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround;
    logic               last_result;
    logic               overflowed;
  } result_t;

  typedef enum logic [2:0] {
    S_LOAD,    // pop jobs from the queue into the store
    S_HLD_RD,  // read entry i
    S_HLD_LD,  // capture entry i, read entry j
    S_CMP,     // compare holder with entry j, exchange if needed
    S_PUT,     // write holder back to entry i
    S_EM_RD,   // read entry k for emission
    S_EM_LD    // load result register
  } back_state_t;

endpackage

// File: hdl/psw_front.sv
// ----------------------------------------------------------------------------
// psw_front
// Accepts jobs, numbers them, marks the ones beyond capacity as dropped.
// ----------------------------------------------------------------------------
module psw_front #(
  parameter int MAX_PROCS  = 16,
  parameter int BURST_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [psw_pkg::BURST_W-1:0]  in_burst_time,
  input  logic [psw_pkg::PRIO_W-1:0]   in_job_priority,
  input  logic                         in_last_job,
  output logic                         q_valid,
  input  logic                         q_stall,
  output psw_pkg::job_item_t           q_item
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int BW    = (BURST_BITS < psw_pkg::BURST_W) ? BURST_BITS : psw_pkg::BURST_W;
  localparam int NW    = psw_pkg::NUM_W;
  localparam logic [psw_pkg::BURST_W-1:0] BURST_MASK =
    {psw_pkg::BURST_W{1'b1}} >> (psw_pkg::BURST_W - BW);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             room;

  assign in_stall = q_stall;
  assign q_valid  = in_valid;
  assign accept   = in_valid && !q_stall;
  assign room     = cnt_r < CNT_W'(MAX_PROCS);

  always_comb begin
    q_item.burst = in_burst_time & BURST_MASK;
    q_item.prio  = in_job_priority;
    q_item.num   = NW'({1'b0, cnt_r} + (CNT_W + 1)'(1));
    q_item.keep  = room;
    q_item.last  = in_last_job;
  end

  // Restart numbering at the end of each set.
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last_job) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/psw_fifo.sv
// ----------------------------------------------------------------------------
// psw_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module psw_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_stall,
  input  psw_pkg::job_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_stall,
  output psw_pkg::job_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  psw_pkg::job_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_stall = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_item   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  a_fifo_fill : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("job queue fill count beyond depth");

endmodule

// File: hdl/psw_back.sv
// ----------------------------------------------------------------------------
// psw_back
// Stores a set of jobs, orders it by exchange sort, emits the schedule.
// ----------------------------------------------------------------------------
module psw_back #(
  parameter int MAX_PROCS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_stall,
  input  psw_pkg::job_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output psw_pkg::result_t   out_res
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int TW    = psw_pkg::TIME_W;

  psw_pkg::back_state_t state_r, state_nxt;

  psw_pkg::entry_t  store_r [MAX_PROCS];
  psw_pkg::entry_t  rdata_r;
  psw_pkg::entry_t  hold_r;
  psw_pkg::entry_t  wr_data;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             mem_we;

  logic [CNT_W-1:0] n_r, n_nxt, n_m1;
  logic             drop_r;
  logic [IDX_W-1:0] i_r, j_r, k_r, last_idx;
  logic [TW-1:0]    wait_r;
  logic             out_valid_r;
  psw_pkg::result_t res_r;

  logic             pop, swap, j_last, sort_done, k_last, load_out;
  logic [TW:0]      tat_sum;
  logic [TW-1:0]    tat_sat;

  assign n_m1      = n_r - CNT_W'(1);
  assign last_idx  = n_m1[IDX_W-1:0];
  assign j_last    = (j_r == last_idx);
  assign k_last    = (k_r == last_idx);
  assign sort_done = ((i_r + IDX_W'(1)) == last_idx);
  assign swap      = (hold_r.prio > rdata_r.prio);
  assign n_nxt     = n_r + CNT_W'(q_item.keep);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psw_pkg::S_LOAD: begin
        if (q_valid && q_item.last) begin
          state_nxt = (n_nxt == CNT_W'(1)) ? psw_pkg::S_EM_RD : psw_pkg::S_HLD_RD;
        end
      end
      psw_pkg::S_HLD_RD: state_nxt = psw_pkg::S_HLD_LD;
      psw_pkg::S_HLD_LD: state_nxt = psw_pkg::S_CMP;
      psw_pkg::S_CMP: begin
        if (j_last) begin
          state_nxt = psw_pkg::S_PUT;
        end
      end
      psw_pkg::S_PUT: begin
        state_nxt = sort_done ? psw_pkg::S_EM_RD : psw_pkg::S_HLD_RD;
      end
      psw_pkg::S_EM_RD: state_nxt = psw_pkg::S_EM_LD;
      psw_pkg::S_EM_LD: begin
        if (load_out) begin
          state_nxt = k_last ? psw_pkg::S_LOAD : psw_pkg::S_EM_RD;
        end
      end
      default: state_nxt = psw_pkg::S_LOAD;
    endcase
  end

  // State outputs: queue pop, store access, result load.
  always_comb begin
    q_stall  = 1'b1;
    pop      = 1'b0;
    mem_we   = 1'b0;
    wr_addr  = '0;
    wr_data  = hold_r;
    rd_addr  = '0;
    load_out = 1'b0;
    case (state_r)
      psw_pkg::S_LOAD: begin
        q_stall       = 1'b0;
        pop           = q_valid;
        mem_we        = q_valid && q_item.keep;
        wr_addr       = n_r[IDX_W-1:0];
        wr_data.burst = q_item.burst;
        wr_data.prio  = q_item.prio;
        wr_data.num   = q_item.num;
      end
      psw_pkg::S_HLD_RD: rd_addr = i_r;
      psw_pkg::S_HLD_LD: rd_addr = i_r + IDX_W'(1);
      psw_pkg::S_CMP: begin
        mem_we  = swap;
        wr_addr = j_r;
        rd_addr = j_last ? j_r : j_r + IDX_W'(1);
      end
      psw_pkg::S_PUT: begin
        mem_we  = 1'b1;
        wr_addr = i_r;
      end
      psw_pkg::S_EM_RD: rd_addr = k_r;
      psw_pkg::S_EM_LD: begin
        rd_addr  = k_r;
        load_out = !out_valid_r || !out_stall;
      end
      default: q_stall = 1'b1;
    endcase
  end

  // Job store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[wr_addr] <= wr_data;
    end
    rdata_r <= store_r[rd_addr];
  end

  assign tat_sum = {1'b0, wait_r} + (TW + 1)'(rdata_r.burst);
  assign tat_sat = tat_sum[TW] ? psw_pkg::TIME_MAX : tat_sum[TW-1:0];

  // Sort and emission indexes, holder, running wait.
  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      i_r    <= '0;
      k_r    <= '0;
      wait_r <= '0;
    end
    if (state_r == psw_pkg::S_HLD_LD) begin
      hold_r <= rdata_r;
      j_r    <= i_r + IDX_W'(1);
    end
    if (state_r == psw_pkg::S_CMP) begin
      if (swap) begin
        hold_r <= rdata_r;
      end
      if (!j_last) begin
        j_r <= j_r + IDX_W'(1);
      end
    end
    if (state_r == psw_pkg::S_PUT) begin
      i_r <= i_r + IDX_W'(1);
    end
    if (load_out) begin
      k_r                <= k_r + IDX_W'(1);
      wait_r             <= tat_sat;
      res_r.job_number   <= rdata_r.num;
      res_r.burst        <= rdata_r.burst;
      res_r.prio         <= rdata_r.prio;
      res_r.wait_time    <= wait_r;
      res_r.turnaround   <= tat_sat;
      res_r.last_result  <= k_last;
      res_r.overflowed   <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psw_pkg::S_LOAD;
      n_r         <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out || (out_valid_r && out_stall);
      if (pop) begin
        n_r    <= n_nxt;
        drop_r <= drop_r || !q_item.keep;
      end else if (load_out && k_last) begin
        n_r    <= '0;
        drop_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_PROCS))
    else $error("job count beyond capacity");

  a_sort_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psw_pkg::S_CMP) |-> (j_r > i_r) && ({1'b0, j_r} < (IDX_W + 1)'(n_r)))
    else $error("sort index out of range");

  a_set_end : assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && k_last) |=> (state_r == psw_pkg::S_LOAD) && (n_r == '0) && !drop_r)
    else $error("set not cleared after final result");

endmodule

// File: hdl/priority_schedule_wait_times.sv
// ----------------------------------------------------------------------------
// priority_schedule_wait_times
// Non-preemptive priority scheduler: collects a job set, orders it by
// priority and emits each job with its waiting and turnaround times.
// ----------------------------------------------------------------------------
// Jobs enter one per transaction and are numbered from 1 in arrival order; the
// transaction with in_last_job set closes the set. Up to MAX_PROCS jobs are
// kept; later ones are dropped and flag out_overflowed on every result of that
// set. Jobs pass through a four-entry queue, so the front end can take up to
// four jobs of the next set while the back end is busy before it stalls. Once
// the set is closed, the back end runs an exchange sort over its job store (one
// write port, one registered read port), then emits the results one at a time,
// each held while out_stall is high. The sort makes one compare per cycle over
// the job store.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times #(
  parameter int MAX_PROCS   = 16,
  parameter int BURST_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // job input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [psw_pkg::BURST_W-1:0]  in_burst_time,
  input  logic [psw_pkg::PRIO_W-1:0]   in_job_priority,
  input  logic                         in_last_job,
  // schedule output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [psw_pkg::NUM_W-1:0]    out_job_number,
  output logic [psw_pkg::BURST_W-1:0]  out_burst,
  output logic [psw_pkg::PRIO_W-1:0]   out_priority,
  output logic [psw_pkg::TIME_W-1:0]   out_wait_time,
  output logic [psw_pkg::TIME_W-1:0]   out_turnaround,
  output logic                         out_last_result,
  output logic                         out_overflowed
);

  // Front end to queue.
  logic               fq_valid, fq_stall;
  psw_pkg::job_item_t fq_item;

  // Queue to back end.
  logic               qb_valid, qb_stall;
  psw_pkg::job_item_t qb_item;

  psw_pkg::result_t   res;

  // Classify: number each job and mark the ones past capacity.
  psw_front #(
    .MAX_PROCS  (MAX_PROCS),
    .BURST_BITS (BURST_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_burst_time   (in_burst_time),
    .in_job_priority (in_job_priority),
    .in_last_job     (in_last_job),
    .q_valid         (fq_valid),
    .q_stall         (fq_stall),
    .q_item          (fq_item)
  );

  // Decouple intake from the sort and emission.
  psw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_stall (fq_stall),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_stall  (qb_stall),
    .pop_item   (qb_item)
  );

  // Store, sort and emit the schedule.
  psw_back #(
    .MAX_PROCS (MAX_PROCS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_stall   (qb_stall),
    .q_item    (qb_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Break the result register out onto the ports.
  assign out_job_number  = res.job_number;
  assign out_burst       = res.burst;
  assign out_priority    = res.prio;
  assign out_wait_time   = res.wait_time;
  assign out_turnaround  = res.turnaround;
  assign out_last_result = res.last_result;
  assign out_overflowed  = res.overflowed;

endmodule
